>>> design/mrd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Metadata record deframer package
// Types and constants shared by the parser, the queue and the result stage.
// ----------------------------------------------------------------------------
package mrd_pkg;

   typedef enum logic [1:0] {
      KIND_KEY     = 2'd0,
      KIND_FIELD   = 2'd1,
      KIND_DATA    = 2'd2,
      KIND_SUMMARY = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_SHORT    = 3'd1,
      ST_NO_MAGIC = 3'd2,
      ST_SMALL    = 3'd3,
      ST_MISMATCH = 3'd4,
      ST_TRUNC    = 3'd5
   } status_type;

   // Record boundaries are sums of a header offset and up to three 32-bit lengths.
   localparam int BOUND_W = 35;
   typedef logic [BOUND_W-1:0] bound_type;

   localparam logic [5:0]  MAGIC_END      = 6'd4;
   localparam logic [5:0]  SIZES_END      = 6'd20;
   localparam logic [5:0]  FIELD_LEN_END  = 6'd24;
   localparam logic [5:0]  LEN_BYTES      = 6'd4;
   localparam logic [5:0]  STATS_BYTES    = 6'd24;
   localparam logic [5:0]  OFF_END_KEY    = 6'd0;
   localparam logic [5:0]  OFF_END_FIELD  = 6'd1;
   localparam logic [5:0]  OFF_END_DATA   = 6'd4;
   localparam logic [31:0] FIELD_META_MIN = 32'd53;
   localparam bound_type   MIN_MAGIC_N    = bound_type'(4);
   localparam bound_type   MIN_HEADER_N   = bound_type'(20);

   localparam logic [7:0] MAGIC [4] = '{8'h52, 8'h44, 8'h4D, 8'h54};

   localparam int QPTR_W = 2;
   localparam int QDEPTH = 1 << QPTR_W;

   typedef struct packed {
      logic        pay_valid;
      kind_type    pay_kind;
      logic [7:0]  pay_byte;
      logic        sum_valid;
      status_type  status;
      logic [7:0]  type_code;
      logic [63:0] access_time;
      logic [63:0] hit_count;
      logic [63:0] miss_count;
      logic [31:0] key_length;
      logic [31:0] field_length;
      logic [31:0] data_length;
      logic [31:0] record_total;
      logic [31:0] meta_total;
   } entry_type;

endpackage
`default_nettype wire

>>> design/mrd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Metadata record deframer front end
// Tracks the byte position, decodes the header, tags body bytes and works out
// the record status on the last beat. Writes one queue entry per useful beat.
// ----------------------------------------------------------------------------
module mrd_front import mrd_pkg::*; #(
   parameter int LENGTH_BITS = 32
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       in_valid,
   input  wire logic [7:0] in_byte,
   input  wire logic       in_last,
   input  wire logic       q_full,
   output logic            push_valid,
   output entry_type       push_data
);

   logic accept;

   logic [LENGTH_BITS-1:0] pos_ff, pos_in;
   logic [LENGTH_BITS:0]   cnt_ff, cnt_in;
   logic                   over_ff, over_in;
   logic                   magic_ff, magic_in;
   logic [31:0]            total_ff, total_in, meta_ff, meta_in, dsize_ff, dsize_in;
   logic [31:0]            klen_ff, klen_in, flen_ff, flen_in, dlen_ff, dlen_in;
   logic [63:0]            atime_ff, atime_in, hits_ff, hits_in, misses_ff, misses_in;
   logic [7:0]             type_ff, type_in;
   bound_type              endk_ff, endk_in, endf_ff, endf_in, endd_ff, endd_in;

   logic       has_field, near_start;
   logic [5:0] low, od, os, ot, oh, off;
   bound_type  pos_w, n_w;
   logic       pay_hit;
   kind_type   pay_kind;
   status_type status;

   assign accept = in_valid && !q_full;

   always_comb begin
      has_field  = (meta_ff >= FIELD_META_MIN);
      od         = has_field ? FIELD_LEN_END : SIZES_END;
      os         = od + LEN_BYTES;
      ot         = os + STATS_BYTES;
      oh         = ot + 6'd1;
      near_start = (pos_ff[LENGTH_BITS-1:6] == '0);
      low        = pos_ff[5:0];
      off        = low - os;
      pos_w      = bound_type'(pos_ff);
      n_w        = bound_type'(cnt_ff);

      magic_in  = magic_ff;
      total_in  = total_ff;
      meta_in   = meta_ff;
      dsize_in  = dsize_ff;
      klen_in   = klen_ff;
      flen_in   = flen_ff;
      dlen_in   = dlen_ff;
      atime_in  = atime_ff;
      hits_in   = hits_ff;
      misses_in = misses_ff;
      type_in   = type_ff;
      endk_in   = endk_ff;
      endf_in   = endf_ff;
      endd_in   = endd_ff;
      pay_hit   = 1'b0;
      pay_kind  = KIND_KEY;

      if (!over_ff) begin
         if (near_start && low < MAGIC_END) begin
            if (in_byte != MAGIC[low[1:0]]) magic_in = 1'b0;
         end else if (near_start && low < SIZES_END) begin
            case (low[4:2])
               3'd1:    total_in = {total_ff[23:0], in_byte};
               3'd2:    meta_in  = {meta_ff[23:0], in_byte};
               3'd3:    dsize_in = {dsize_ff[23:0], in_byte};
               default: klen_in  = {klen_ff[23:0], in_byte};
            endcase
         end else if (near_start && low < od) begin
            flen_in = {flen_ff[23:0], in_byte};
         end else if (near_start && low < os) begin
            dlen_in = {dlen_ff[23:0], in_byte};
         end else if (near_start && low < ot) begin
            case (off[4:3])
               2'd0:    atime_in  = {atime_ff[55:0], in_byte};
               2'd1:    hits_in   = {hits_ff[55:0], in_byte};
               default: misses_in = {misses_ff[55:0], in_byte};
            endcase
            // The body boundaries are summed one at a time while the counters stream in.
            if (off == OFF_END_KEY)   endk_in = bound_type'(oh) + bound_type'(klen_ff);
            if (off == OFF_END_FIELD) endf_in = endk_ff + bound_type'(flen_ff);
            if (off == OFF_END_DATA)  endd_in = endf_ff + bound_type'(dlen_ff);
         end else if (near_start && low == ot) begin
            type_in = in_byte;
         end else begin
            if (pos_w < endk_ff) begin
               pay_hit  = 1'b1;
               pay_kind = KIND_KEY;
            end else if (pos_w < endf_ff) begin
               pay_hit  = 1'b1;
               pay_kind = KIND_FIELD;
            end else if (pos_w < endd_ff) begin
               pay_hit  = 1'b1;
               pay_kind = KIND_DATA;
            end
         end
      end

      // The first failing check sets the status; this beat's magic and data-length updates count.
      if (!over_ff && n_w < MIN_MAGIC_N)                  status = ST_SHORT;
      else if (!magic_in)                                 status = ST_NO_MAGIC;
      else if (!over_ff && n_w < MIN_HEADER_N)            status = ST_SMALL;
      else if (over_ff || bound_type'(total_ff) != n_w)   status = ST_MISMATCH;
      else if (n_w < bound_type'(os))                     status = ST_TRUNC;
      else if (dlen_in != dsize_ff)                       status = ST_MISMATCH;
      else if (n_w < bound_type'(oh))                     status = ST_TRUNC;
      else if (endk_ff > n_w)                             status = ST_TRUNC;
      else if (flen_ff != '0 && endf_ff > n_w)            status = ST_TRUNC;
      else if (endd_ff > n_w)                             status = ST_TRUNC;
      else                                                status = ST_OK;

      pos_in  = pos_ff;
      cnt_in  = cnt_ff;
      over_in = over_ff;
      if (pos_ff == '1) begin
         over_in = 1'b1;
      end else begin
         pos_in = pos_ff + 1'b1;
         cnt_in = cnt_ff + 1'b1;
      end

      push_valid             = accept && (pay_hit || in_last);
      push_data.pay_valid    = pay_hit;
      push_data.pay_kind     = pay_kind;
      push_data.pay_byte     = in_byte;
      push_data.sum_valid    = in_last;
      push_data.status       = status;
      push_data.type_code    = type_in;
      push_data.access_time  = atime_in;
      push_data.hit_count    = hits_in;
      push_data.miss_count   = misses_in;
      push_data.key_length   = klen_in;
      push_data.field_length = flen_in;
      push_data.data_length  = dlen_in;
      push_data.record_total = total_in;
      push_data.meta_total   = meta_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && in_last)) begin
         pos_ff    <= '0;
         cnt_ff    <= (LENGTH_BITS+1)'(1);
         over_ff   <= 1'b0;
         magic_ff  <= 1'b1;
         total_ff  <= '0;
         meta_ff   <= '0;
         dsize_ff  <= '0;
         klen_ff   <= '0;
         flen_ff   <= '0;
         dlen_ff   <= '0;
         atime_ff  <= '0;
         hits_ff   <= '0;
         misses_ff <= '0;
         type_ff   <= '0;
         endk_ff   <= '0;
         endf_ff   <= '0;
         endd_ff   <= '0;
      end else if (accept) begin
         pos_ff    <= pos_in;
         cnt_ff    <= cnt_in;
         over_ff   <= over_in;
         magic_ff  <= magic_in;
         total_ff  <= total_in;
         meta_ff   <= meta_in;
         dsize_ff  <= dsize_in;
         klen_ff   <= klen_in;
         flen_ff   <= flen_in;
         dlen_ff   <= dlen_in;
         atime_ff  <= atime_in;
         hits_ff   <= hits_in;
         misses_ff <= misses_in;
         type_ff   <= type_in;
         endk_ff   <= endk_in;
         endf_ff   <= endf_in;
         endd_ff   <= endd_in;
      end
   end

endmodule
`default_nettype wire

>>> design/mrd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Metadata record deframer queue
// Small first-in first-out buffer of parsed entries between front and back.
// ----------------------------------------------------------------------------
module mrd_queue import mrd_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire entry_type push_data,
   input  wire logic      pop,
   output logic           full,
   output logic           empty,
   output entry_type      head
);

   entry_type         mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]   count_ff, count_in;

   assign full  = (count_ff == (QPTR_W+1)'(QDEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

endmodule
`default_nettype wire

>>> design/mrd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Metadata record deframer back end
// Turns queue entries into result beats: the tagged byte first, then the
// summary, held in an output register until the consumer takes each one.
// ----------------------------------------------------------------------------
module mrd_back import mrd_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      q_empty,
   input  wire entry_type head,
   output logic           pop,
   output logic           rsp_valid,
   input  wire logic      rsp_ready,
   output logic [1:0]     rsp_out_kind,
   output logic [7:0]     rsp_out_byte,
   output logic [2:0]     rsp_parse_status,
   output logic [7:0]     rsp_type_code,
   output logic [63:0]    rsp_access_time,
   output logic [63:0]    rsp_hit_count,
   output logic [63:0]    rsp_miss_count,
   output logic [31:0]    rsp_key_length,
   output logic [31:0]    rsp_field_length,
   output logic [31:0]    rsp_data_length,
   output logic [31:0]    rsp_record_total,
   output logic [31:0]    rsp_meta_total
);

   logic       valid_ff, valid_in;
   logic       pay_done_ff, pay_done_in;
   logic       load, take_pay, show_hdr;
   kind_type   kind_ff, kind_in;
   status_type status_ff, status_in;
   logic [7:0] byte_ff, byte_in;
   entry_type  hdr_ff, hdr_in;

   always_comb begin
      load     = (!valid_ff || rsp_ready) && !q_empty;
      take_pay = head.pay_valid && !pay_done_ff;
      show_hdr = !take_pay && (head.status == ST_OK);
      // An entry holding both a byte and the summary stays at the head until both are loaded.
      pop      = load && (!take_pay || !head.sum_valid);

      pay_done_in = pay_done_ff;
      valid_in    = valid_ff;
      if (load) begin
         pay_done_in = take_pay && head.sum_valid;
         valid_in    = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end

      kind_in   = take_pay ? head.pay_kind : KIND_SUMMARY;
      byte_in   = take_pay ? head.pay_byte : 8'd0;
      status_in = take_pay ? ST_OK : head.status;
      hdr_in    = show_hdr ? head : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         pay_done_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         pay_done_ff <= pay_done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff   <= kind_in;
         byte_ff   <= byte_in;
         status_ff <= status_in;
         hdr_ff    <= hdr_in;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_out_kind     = kind_ff;
   assign rsp_out_byte     = byte_ff;
   assign rsp_parse_status = status_ff;
   assign rsp_type_code    = hdr_ff.type_code;
   assign rsp_access_time  = hdr_ff.access_time;
   assign rsp_hit_count    = hdr_ff.hit_count;
   assign rsp_miss_count   = hdr_ff.miss_count;
   assign rsp_key_length   = hdr_ff.key_length;
   assign rsp_field_length = hdr_ff.field_length;
   assign rsp_data_length  = hdr_ff.data_length;
   assign rsp_record_total = hdr_ff.record_total;
   assign rsp_meta_total   = hdr_ff.meta_total;

endmodule
`default_nettype wire

>>> design/metadata_record_deframer_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Metadata record deframer
// Parses a byte-framed metadata record and streams its key, field and data
// bytes followed by a summary beat with the status and decoded header.
// ----------------------------------------------------------------------------
// The block takes one record byte per cycle while the queue is not full. The
// front end decodes the header and tags each body byte in the cycle it is
// accepted and writes an entry to a four-entry queue; the back end drains the
// queue into a registered output. Each queue entry costs one output beat,
// except the last byte of a record when it is itself a body byte, which costs
// two (the byte and then the summary). Input stalls only when the queue is
// full. On a summary beat that is not OK, the header fields read zero and the
// body bytes already passed for that record should be dropped. Body bytes past
// the declared key, field and data lengths are silently ignored.
module metadata_record_deframer_unit import mrd_pkg::*; #(
   parameter int LENGTH_BITS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_in_byte,
   input  wire logic        req_in_last,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_out_kind,
   output logic [7:0]       rsp_out_byte,
   output logic [2:0]       rsp_parse_status,
   output logic [7:0]       rsp_type_code,
   output logic [63:0]      rsp_access_time,
   output logic [63:0]      rsp_hit_count,
   output logic [63:0]      rsp_miss_count,
   output logic [31:0]      rsp_key_length,
   output logic [31:0]      rsp_field_length,
   output logic [31:0]      rsp_data_length,
   output logic [31:0]      rsp_record_total,
   output logic [31:0]      rsp_meta_total
);

   logic      push_valid, q_full, q_empty, pop;
   entry_type push_data, head;

   assign req_ready = !q_full;

   mrd_front #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_byte    (req_in_byte),
      .in_last    (req_in_last),
      .q_full     (q_full),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   mrd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data (push_data),
      .pop       (pop),
      .full      (q_full),
      .empty     (q_empty),
      .head      (head)
   );

   mrd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .head             (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_kind     (rsp_out_kind),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_parse_status (rsp_parse_status),
      .rsp_type_code    (rsp_type_code),
      .rsp_access_time  (rsp_access_time),
      .rsp_hit_count    (rsp_hit_count),
      .rsp_miss_count   (rsp_miss_count),
      .rsp_key_length   (rsp_key_length),
      .rsp_field_length (rsp_field_length),
      .rsp_data_length  (rsp_data_length),
      .rsp_record_total (rsp_record_total),
      .rsp_meta_total   (rsp_meta_total)
   );

   // A last beat always leaves a summary entry behind in the queue.
   a_last_queued: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_in_last) |=> !q_empty)
      else $error("last beat accepted but queue is empty");

   // Body byte beats carry no status and no header.
   a_body_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_kind != KIND_SUMMARY) |->
         (rsp_parse_status == ST_OK && rsp_key_length == '0 && rsp_access_time == '0))
      else $error("body beat carries status or header");

   // A failed summary hides the header.
   a_fail_hidden: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_kind == KIND_SUMMARY && rsp_parse_status != ST_OK) |->
         (rsp_record_total == '0 && rsp_hit_count == '0 && rsp_out_byte == '0))
      else $error("failed summary shows header values");

   // The queue never pops while empty or pushes while full.
   a_queue_sane: assert property (@(posedge clock) disable iff (reset)
      !(pop && q_empty) && !(push_valid && q_full))
      else $error("queue overrun or underrun");

endmodule
`default_nettype wire
